@@ hdl/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types, character codes and small lookup functions for the
// position string syntax checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

   localparam int unsigned CH_WIDTH = 8;

   typedef logic [CH_WIDTH-1:0] ch_type;

   // Which space-separated field of the string is being parsed.
   typedef enum logic [2:0] {
      FLD_BOARD    = 3'd0,
      FLD_TURN     = 3'd1,
      FLD_CASTLE   = 3'd2,
      FLD_EP       = 3'd3,
      FLD_HALFMOVE = 3'd4,
      FLD_FULLMOVE = 3'd5,
      FLD_TAIL     = 3'd6
   } field_type;

   // Per-beat control handed from the top level to the checking units.
   typedef struct packed {
      logic take;    // a non-space byte is consumed
      logic finish;  // the current token ends on this beat
      logic clear;   // the string ends on this beat
   } step_type;

   localparam ch_type CH_SPACE = 8'h20;
   localparam ch_type CH_SLASH = 8'h2F;
   localparam ch_type CH_DASH  = 8'h2D;
   localparam ch_type CH_ZERO  = 8'h30;
   localparam ch_type CH_ONE   = 8'h31;
   localparam ch_type CH_THREE = 8'h33;
   localparam ch_type CH_SIX   = 8'h36;
   localparam ch_type CH_EIGHT = 8'h38;
   localparam ch_type CH_NINE  = 8'h39;
   localparam ch_type CH_LO_A  = 8'h61;
   localparam ch_type CH_LO_H  = 8'h68;
   localparam ch_type CH_LO_W  = 8'h77;
   localparam ch_type CH_LO_B  = 8'h62;
   localparam ch_type CH_LO_K  = 8'h6B;
   localparam ch_type CH_LO_Q  = 8'h71;
   localparam ch_type CH_LO_R  = 8'h72;
   localparam ch_type CH_LO_N  = 8'h6E;
   localparam ch_type CH_LO_P  = 8'h70;
   localparam ch_type CH_UP_K  = 8'h4B;
   localparam ch_type CH_UP_Q  = 8'h51;
   localparam ch_type CH_UP_R  = 8'h52;
   localparam ch_type CH_UP_N  = 8'h4E;
   localparam ch_type CH_UP_B  = 8'h42;
   localparam ch_type CH_UP_P  = 8'h50;

   localparam logic [3:0] RANK_FULL    = 4'd8;
   localparam logic [3:0] RANK_SAT     = 4'd9;
   localparam logic [3:0] SLASH_NEEDED = 4'd7;
   localparam logic [3:0] SLASH_SAT    = 4'd8;
   localparam logic [1:0] KING_SAT     = 2'd2;
   localparam logic [3:0] TOKEN_SAT    = 4'd10;
   localparam logic [3:0] CLOCK_MAX    = 4'd9;

   function automatic logic is_piece(input ch_type c);
      logic hit;
      case (c)
         CH_LO_R, CH_LO_N, CH_LO_B, CH_LO_Q, CH_LO_K, CH_LO_P,
         CH_UP_R, CH_UP_N, CH_UP_B, CH_UP_Q, CH_UP_K, CH_UP_P: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic [3:0] castle_bit(input ch_type c);
      logic [3:0] bit_mask;
      case (c)
         CH_UP_K: bit_mask = 4'b0001;
         CH_UP_Q: bit_mask = 4'b0010;
         CH_LO_K: bit_mask = 4'b0100;
         CH_LO_Q: bit_mask = 4'b1000;
         default: bit_mask = 4'b0000;
      endcase
      return bit_mask;
   endfunction

endpackage

`default_nettype wire

@@ hdl/fsc_req_if.sv @@
// ----------------------------------------------------------------------------
// fsc_req_if
// Request channel: one string byte per beat with an end-of-string marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/fsc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fsc_rsp_if
// Response channel: one pass/fail bit per string.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsc_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;

   modport source (output valid, output valid_res, input ready);
   modport sink   (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

@@ hdl/fsc_board.sv @@
// ----------------------------------------------------------------------------
// fsc_board
// Board field checker: rank column sums, slash count and king counts.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_board (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fsc_pkg::step_type step,
   input  wire fsc_pkg::field_type field,
   input  wire fsc_pkg::ch_type   ch,
   output logic                   bad
);
   import fsc_pkg::*;

   logic [3:0] rank_ff, rank_in, rank_t;
   logic [3:0] sep_ff, sep_in, sep_t;
   logic [1:0] wk_ff, wk_in, wk_t;
   logic [1:0] bk_ff, bk_in, bk_t;
   logic [4:0] rank_sum;
   logic       active;
   logic       char_bad;
   logic       end_bad;

   assign active   = (field == FLD_BOARD);
   assign rank_sum = {1'b0, rank_ff} + {1'b0, ch[3:0]};

   // Values after this byte is taken; the end-of-field check looks at these.
   always_comb begin
      rank_t   = rank_ff;
      sep_t    = sep_ff;
      wk_t     = wk_ff;
      bk_t     = bk_ff;
      char_bad = 1'b0;
      if (step.take && active) begin
         if (ch == CH_SLASH) begin
            char_bad = (rank_ff != RANK_FULL);
            rank_t   = '0;
            if (sep_ff < SLASH_SAT) sep_t = sep_ff + 4'd1;
         end else if (ch >= CH_ONE && ch <= CH_EIGHT) begin
            rank_t = (rank_sum > {1'b0, RANK_SAT}) ? RANK_SAT : rank_sum[3:0];
         end else if (is_piece(ch)) begin
            if (ch == CH_UP_K && wk_ff < KING_SAT) wk_t = wk_ff + 2'd1;
            if (ch == CH_LO_K && bk_ff < KING_SAT) bk_t = bk_ff + 2'd1;
            if (rank_ff < RANK_SAT) rank_t = rank_ff + 4'd1;
         end else begin
            char_bad = 1'b1;
         end
      end
   end

   assign end_bad = step.finish && active &&
                    (sep_t != SLASH_NEEDED || rank_t != RANK_FULL ||
                     wk_t != 2'd1 || bk_t != 2'd1);
   assign bad = char_bad || end_bad;

   always_comb begin
      if (step.clear) begin
         rank_in = '0;
         sep_in  = '0;
         wk_in   = '0;
         bk_in   = '0;
      end else begin
         rank_in = rank_t;
         sep_in  = sep_t;
         wk_in   = wk_t;
         bk_in   = bk_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
         sep_ff  <= '0;
         wk_ff   <= '0;
         bk_ff   <= '0;
      end else begin
         rank_ff <= rank_in;
         sep_ff  <= sep_in;
         wk_ff   <= wk_in;
         bk_ff   <= bk_in;
      end
   end

   a_rank_bounded: assert property (@(posedge clock) disable iff (reset)
      rank_ff <= RANK_SAT && sep_ff <= SLASH_SAT)
      else $error("board counters beyond saturation");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      step.clear |=> (rank_ff == '0 && sep_ff == '0 && wk_ff == '0 && bk_ff == '0))
      else $error("board state not cleared at end of string");

   a_idle_outside_board: assert property (@(posedge clock) disable iff (reset)
      (!active && !step.clear) |=> $stable(rank_ff) && $stable(sep_ff))
      else $error("board counters moved outside the board field");

endmodule

`default_nettype wire

@@ hdl/fsc_fields.sv @@
// ----------------------------------------------------------------------------
// fsc_fields
// Checker for the fields after the board: turn, castling, en passant and
// the two move clocks.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_fields (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fsc_pkg::step_type  step,
   input  wire fsc_pkg::field_type field,
   input  wire fsc_pkg::ch_type    ch,
   output logic                    bad
);
   import fsc_pkg::*;

   logic [3:0] len_ff, len_in, len_t;
   ch_type     first_ff, first_in, first_t;
   logic [3:0] castle_ff, castle_in, castle_t;
   logic       nonzero_ff, nonzero_in, nonzero_t;
   logic [3:0] cbit;
   logic       counts;
   logic       char_bad;
   logic       end_bad;

   assign cbit   = castle_bit(ch);
   assign counts = step.take && field != FLD_BOARD && field != FLD_TAIL;

   always_comb begin
      castle_t  = castle_ff;
      nonzero_t = nonzero_ff;
      char_bad  = 1'b0;
      if (counts) begin
         case (field)
            FLD_CASTLE: begin
               if (ch == CH_DASH) begin
                  char_bad = (len_ff != '0);
               end else if (len_ff != '0 && first_ff == CH_DASH) begin
                  char_bad = 1'b1;
               end else begin
                  char_bad = (cbit == '0) || ((castle_ff & cbit) != '0);
                  castle_t = castle_ff | cbit;
               end
            end
            FLD_EP: begin
               // The first byte was stored on the previous beat of this token.
               if (len_ff == 4'd1) begin
                  char_bad = first_ff < CH_LO_A || first_ff > CH_LO_H ||
                             (ch != CH_THREE && ch != CH_SIX);
               end else if (len_ff >= 4'd2) begin
                  char_bad = 1'b1;
               end
            end
            FLD_HALFMOVE, FLD_FULLMOVE: begin
               char_bad = ch < CH_ZERO || ch > CH_NINE;
               if (field == FLD_FULLMOVE && ch != CH_ZERO) nonzero_t = 1'b1;
            end
            default: begin
               char_bad = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      len_t   = len_ff;
      first_t = first_ff;
      if (counts) begin
         if (len_ff == '0) first_t = ch;
         if (len_ff < TOKEN_SAT) len_t = len_ff + 4'd1;
      end
   end

   always_comb begin
      end_bad = 1'b0;
      if (step.finish) begin
         case (field)
            FLD_TURN:
               end_bad = len_t != 4'd1 || (first_t != CH_LO_W && first_t != CH_LO_B);
            FLD_EP:
               end_bad = len_t == '0 || (len_t == 4'd1 && first_t != CH_DASH);
            FLD_HALFMOVE:
               end_bad = len_t == '0 || len_t > CLOCK_MAX;
            FLD_FULLMOVE:
               end_bad = len_t == '0 || len_t > CLOCK_MAX || !nonzero_t;
            default:
               end_bad = 1'b0;
         endcase
      end
   end

   assign bad = char_bad || end_bad;

   always_comb begin
      len_in     = len_t;
      first_in   = first_t;
      castle_in  = castle_t;
      nonzero_in = nonzero_t;
      if (step.finish || step.clear) begin
         len_in    = '0;
         first_in  = '0;
         castle_in = '0;
      end
      if (step.clear) nonzero_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         first_ff   <= '0;
         castle_ff  <= '0;
         nonzero_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         first_ff   <= first_in;
         castle_ff  <= castle_in;
         nonzero_ff <= nonzero_in;
      end
   end

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      len_ff <= TOKEN_SAT)
      else $error("token length beyond saturation");

   a_token_restart: assert property (@(posedge clock) disable iff (reset)
      (step.finish || step.clear) |=> (len_ff == '0 && castle_ff == '0))
      else $error("token state not cleared at token end");

   a_first_kept: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0 && !step.finish && !step.clear) |=> $stable(first_ff))
      else $error("first byte of token overwritten");

endmodule

`default_nettype wire

@@ hdl/fen_syntax_checker.sv @@
// ----------------------------------------------------------------------------
// fen_syntax_checker
// Streaming syntax check of a chess position string, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one byte of the string per beat; last marks
//   the final byte. Exactly one response beat is produced per string, on the
//   final byte, with valid_res high when every syntax check passed.
//   Bytes enter an input register, are checked by shallow logic against the
//   per-string counters, and the verdict lands in a result register.
//   The response is registered; the final byte passes the input register first.
//   Throughput: one byte per cycle, back to back, also across string ends.
//   When the receiver stalls, bytes that are not final keep flowing; a final
//   byte waits in the input register until the result register is free, and
//   the request side then stalls behind it.
//   Reset clears the parser to the board field and empties both registers.
//   All parse state clears by itself after each string.
// ----------------------------------------------------------------------------
`default_nettype none

module fen_syntax_checker (
   input  wire logic clock,
   input  wire logic reset,
   fsc_req_if.sink   req_chan,
   fsc_rsp_if.source rsp_chan
);
   import fsc_pkg::*;

   logic      in_valid_ff;
   ch_type    in_ch_ff;
   logic      in_last_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_res_ff;
   field_type field_ff, field_in;
   logic      failed_ff, failed_in;
   logic      out_free;
   logic      advance;
   logic      accept;
   logic      board_bad;
   logic      fields_bad;
   logic      beat_bad;
   step_type  step;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!in_last_ff || out_free);
   assign accept   = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff   <= req_chan.ch;
         in_last_ff <= req_chan.last;
      end
   end

   // Beat decode: a space ends the token, the final byte ends it too.
   always_comb begin
      step.take   = advance && (in_ch_ff != CH_SPACE);
      step.finish = advance && (field_ff != FLD_TAIL) &&
                    ((in_ch_ff == CH_SPACE) || in_last_ff);
      step.clear  = advance && in_last_ff;
   end

   fsc_board u_board (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .field (field_ff),
      .ch    (in_ch_ff),
      .bad   (board_bad)
   );

   fsc_fields u_fields (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .field (field_ff),
      .ch    (in_ch_ff),
      .bad   (fields_bad)
   );

   assign beat_bad = board_bad || fields_bad;

   // Next state of the field sequencer.
   always_comb begin
      field_in = field_ff;
      if (step.clear) begin
         field_in = FLD_BOARD;
      end else if (step.finish) begin
         case (field_ff)
            FLD_BOARD:    field_in = FLD_TURN;
            FLD_TURN:     field_in = FLD_CASTLE;
            FLD_CASTLE:   field_in = FLD_EP;
            FLD_EP:       field_in = FLD_HALFMOVE;
            FLD_HALFMOVE: field_in = FLD_FULLMOVE;
            default:      field_in = FLD_TAIL;
         endcase
      end
   end

   // Verdict and response register.
   always_comb begin
      failed_in = step.clear ? 1'b0 : (failed_ff || beat_bad);
      if (step.clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff     <= FLD_BOARD;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         field_ff     <= field_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.clear) rsp_res_ff <= !(failed_ff || beat_bad);
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.valid_res = rsp_res_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("response raised without a final byte");

   a_string_restart: assert property (@(posedge clock) disable iff (reset)
      step.clear |=> (field_ff == FLD_BOARD && !failed_ff))
      else $error("parser did not restart after end of string");

   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && !out_free) |=> (in_valid_ff && in_last_ff))
      else $error("final byte dropped while response stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !step.clear)
      else $error("pending response overwritten");

endmodule

`default_nettype wire
